// ----- src/dsss_pkg.sv -----
// Shared types and constants for the diagonal state-space scan.
// Holds the in/out word structs, lane control struct and fixed-point helpers.
// No dependencies.
package dsss_pkg;

    localparam int unsigned CHAN_W    = 6;
    localparam int unsigned DATA_W    = 16;
    localparam int unsigned STATE_W   = 32;
    localparam int unsigned LANE_MAX  = 4;
    localparam int unsigned CFG_IDX_W = 4;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_3 = CFG_IDX_W'(3);

    typedef struct packed {
        logic        [CHAN_W-1:0] channel;
        logic                     seq_start;
        logic signed [DATA_W-1:0] sample_in;
        logic signed [DATA_W-1:0] in_weight_0;
        logic signed [DATA_W-1:0] in_weight_1;
        logic signed [DATA_W-1:0] in_weight_2;
        logic signed [DATA_W-1:0] in_weight_3;
        logic signed [DATA_W-1:0] out_weight_0;
        logic signed [DATA_W-1:0] out_weight_1;
        logic signed [DATA_W-1:0] out_weight_2;
        logic signed [DATA_W-1:0] out_weight_3;
    } t_in_word;

    typedef struct packed {
        logic        [CHAN_W-1:0]  channel_out;
        logic signed [STATE_W-1:0] sample_out;
    } t_out_word;

    // Stage enables for one lane datapath
    typedef struct packed {
        logic mul_en;   // latch a*h and b*x
        logic upd_en;   // latch the new hidden state
        logic prod_en;  // latch c*h
    } t_lane_ctl;

    // Saturate a signed value to the 32-bit range
    function automatic logic signed [STATE_W-1:0] f_sat32(input logic signed [37:0] v);
        logic signed [37:0] hi;
        logic signed [37:0] lo;
        hi = 38'sh0_7FFF_FFFF;
        lo = -38'sh0_8000_0000;
        if (v > hi) begin
            f_sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            f_sat32 = 32'sh8000_0000;
        end else begin
            f_sat32 = v[STATE_W-1:0];
        end
    endfunction

endpackage

// ----- src/diagonal_state_space_scan.sv -----
// Diagonal state-space scan, top level: control sequencer, decay registers,
// hidden-state RAM and output register. Depends on dsss_pkg, dsss_ram, dsss_lane.
// Result: registered after the multiply, update, product and sum steps.
// A new word is taken only once the last one has left the sum step, after
// the read-modify-write of its RAM entry (read, multiply, update, write back).
// Reset: synchronous, active low; then a clearing pass over all CHANNELS
// entries zeroes the RAM, during which no input word is taken (config still is).
module diagonal_state_space_scan #(
    parameter int unsigned CHANNELS    = 64,
    parameter int unsigned STATE_LANES = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input words
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  dsss_pkg::t_in_word                 i_in,
    // result words
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output dsss_pkg::t_out_word                o_out,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dsss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dsss_pkg::DATA_W-1:0]        i_cfg_data
);
    import dsss_pkg::*;

    localparam int unsigned AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned MEM_W = STATE_W * STATE_LANES;
    localparam int unsigned EXT_W = AW + CHAN_W;

    // Sequencer: clear pass, then per word read -> multiply -> update ->
    // write back and output product -> sum into the output register.
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_UPD   = 6'b001000,
        ST_PROD  = 6'b010000,
        ST_SUM   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0]             r_clr_addr;
    logic [AW-1:0]             r_addr;
    logic                      r_in_range;
    t_in_word                  r_item;
    logic signed [DATA_W-1:0]  r_decay [0:LANE_MAX-1];
    logic                      r_out_valid;
    t_out_word                 r_out;

    logic                      w_in_acc;
    logic                      w_out_free;
    logic [EXT_W-1:0]          w_ch_ext;
    logic                      w_wr_en;
    logic [AW-1:0]             w_wr_addr;
    logic [MEM_W-1:0]          w_wr_data;
    logic [MEM_W-1:0]          w_rd_data;
    logic [MEM_W-1:0]          w_h_new;
    t_lane_ctl                 w_ctl;
    logic signed [DATA_W-1:0]  w_b [0:LANE_MAX-1];
    logic signed [DATA_W-1:0]  w_c [0:LANE_MAX-1];
    logic signed [47:0]        w_prod [0:LANE_MAX-1];
    logic signed [49:0]        w_acc;
    logic signed [37:0]        w_acc_shr;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_ch_ext   = EXT_W'(i_in.channel);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Decay registers; indexes past the last register are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_MAX; k++) begin
                r_decay[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DECAY_0: r_decay[0] <= i_cfg_data;
                REG_DECAY_1: r_decay[1] <= i_cfg_data;
                REG_DECAY_2: r_decay[2] <= i_cfg_data;
                REG_DECAY_3: r_decay[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(CHANNELS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_UPD;
            ST_UPD:  n_state = ST_PROD;
            ST_PROD: n_state = ST_SUM;
            ST_SUM: begin
                // hold here until the output register can take the word
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // Capture the accepted word and its RAM address
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item     <= i_in;
            r_addr     <= w_ch_ext[AW-1:0];
            r_in_range <= (32'(i_in.channel) < CHANNELS);
        end
    end

    // RAM: read at accept, write back once the new state is latched.
    // Only one word is in flight, so a read never meets a pending write.
    assign w_wr_en   = (r_state == ST_CLEAR) || ((r_state == ST_PROD) && r_in_range);
    assign w_wr_addr = (r_state == ST_CLEAR) ? r_clr_addr : r_addr;
    assign w_wr_data = (r_state == ST_CLEAR) ? '0 : w_h_new;

    dsss_ram #(
        .WIDTH (MEM_W),
        .DEPTH (CHANNELS)
    ) u_hidden_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_ch_ext[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_ctl.mul_en  = (r_state == ST_MUL);
    assign w_ctl.upd_en  = (r_state == ST_UPD);
    assign w_ctl.prod_en = (r_state == ST_PROD);

    assign w_b[0] = r_item.in_weight_0;
    assign w_b[1] = r_item.in_weight_1;
    assign w_b[2] = r_item.in_weight_2;
    assign w_b[3] = r_item.in_weight_3;
    assign w_c[0] = r_item.out_weight_0;
    assign w_c[1] = r_item.out_weight_1;
    assign w_c[2] = r_item.out_weight_2;
    assign w_c[3] = r_item.out_weight_3;

    // Active lanes; seq_start zeroes the old state on its way into the lane
    for (genvar n = 0; n < LANE_MAX; n++) begin : g_lane
        if (n < STATE_LANES) begin : g_on
            logic signed [STATE_W-1:0] w_h_old;
            logic signed [STATE_W-1:0] w_h_lane;

            assign w_h_old = r_item.seq_start ? '0 : w_rd_data[n*STATE_W +: STATE_W];

            dsss_lane u_lane (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_decay (r_decay[n]),
                .i_h_old (w_h_old),
                .i_b     (w_b[n]),
                .i_x     (r_item.sample_in),
                .i_c     (w_c[n]),
                .o_h_new (w_h_lane),
                .o_prod  (w_prod[n])
            );

            assign w_h_new[n*STATE_W +: STATE_W] = w_h_lane;
        end else begin : g_off
            assign w_prod[n] = '0;
        end
    end

    // Sum the four Q.28 products, floor shift by 12, saturate
    assign w_acc     = 50'(w_prod[0]) + 50'(w_prod[1]) + 50'(w_prod[2]) + 50'(w_prod[3]);
    assign w_acc_shr = w_acc[49:12];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_SUM) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SUM) && w_out_free) begin
            r_out.channel_out <= r_item.channel;
            // out-of-range channel gives a zero sample
            r_out.sample_out  <= r_in_range ? f_sat32(w_acc_shr) : '0;
        end
    end

    // An accepted word always starts the multiply step
    a_acc_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_MUL))
        else $error("accepted word did not enter the multiply step");

    // RAM writes only from the clear pass or the write-back step
    a_wr_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> ((r_state == ST_CLEAR) || (r_state == ST_PROD)))
        else $error("RAM written outside clear pass or write-back");

    // A result is loaded only from the sum step
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_SUM))
        else $error("result word appeared without a sum step");

endmodule

// ----- src/dsss_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module dsss_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/dsss_lane.sv -----
// One state lane: h = a*h + b*x in Q16.16, then the output product c*h.
// Depends on dsss_pkg for t_lane_ctl and f_sat32.
module dsss_lane (
    input  logic                                 i_clk,
    input  dsss_pkg::t_lane_ctl                  i_ctl,
    input  logic signed [dsss_pkg::DATA_W-1:0]   i_decay,
    input  logic signed [dsss_pkg::STATE_W-1:0]  i_h_old,
    input  logic signed [dsss_pkg::DATA_W-1:0]   i_b,
    input  logic signed [dsss_pkg::DATA_W-1:0]   i_x,
    input  logic signed [dsss_pkg::DATA_W-1:0]   i_c,
    output logic signed [dsss_pkg::STATE_W-1:0]  o_h_new,
    output logic signed [47:0]                   o_prod
);
    import dsss_pkg::*;

    logic signed [47:0]        r_ah;
    logic signed [31:0]        r_bx;
    logic signed [STATE_W-1:0] r_h;
    logic signed [47:0]        r_prod;
    logic signed [48:0]        w_sum;
    logic signed [37:0]        w_shr;

    // Q.28 sum; b*x is Q.24 so scale by 16
    assign w_sum = 49'(r_ah) + (49'(r_bx) <<< 4);
    // Floor shift by 12
    assign w_shr = 38'($signed(w_sum[48:12]));

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_ah <= 48'(i_decay) * 48'(i_h_old);
            r_bx <= 32'(i_b) * 32'(i_x);
        end
        if (i_ctl.upd_en) begin
            r_h <= f_sat32(w_shr);
        end
        if (i_ctl.prod_en) begin
            r_prod <= 48'(i_c) * 48'(r_h);
        end
    end

    assign o_h_new = r_h;
    assign o_prod  = r_prod;

endmodule
